FILE: rtl/core/grid_min_cost_path_unit_assert.svh
// Assertion macros shared by the RTL of the grid minimum cost path unit.
`ifndef GRID_MIN_COST_PATH_UNIT_ASSERT_SVH
`define GRID_MIN_COST_PATH_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define GMCP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define GMCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/gmcp_pkg.sv
package gmcp_pkg;

   // Depth of the line store that holds one row of accumulated costs.
   localparam int MAX_COLS    = 1024;
   localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int COLS_LIMIT  = (MAX_COLS < 1024) ? MAX_COLS : 1024;

   localparam int ROWS_LIMIT  = 4096;
   localparam int ROW_W       = 12;

   localparam int COST_W      = 16;
   localparam int PATH_W      = 32;

   localparam int NUM_ROWS_W  = 13;
   localparam int NUM_COLS_W  = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 13;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS = 2'd1;

   typedef logic [ROW_W-1:0]         row_pos_type;
   typedef logic [COL_W-1:0]         col_pos_type;
   typedef logic signed [PATH_W-1:0] path_type;

   // Signed minimum; the first operand wins a tie.
   function automatic path_type path_min(input path_type a, input path_type b);
      return (a <= b) ? a : b;
   endfunction

endpackage

FILE: rtl/core/grid_min_cost_path_unit.sv
// Channel  | Direction | Fields (lowest bit first)
// ---------+-----------+----------------------------------------------------
// req_     | in        | tdata: cell_cost[15:0] (signed)
// rsp_     | out       | tdata: path_cost[31:0] (signed); tlast: is_final
// csr_     | in        | write only: index 0 num_rows, index 1 num_cols
//
// One cell is accepted per cycle unless the output stalls. The line store is
// read at the edge that accepts a cell, the add and minimum follow in the next
// cycle, and the result then passes through the output register to rsp_.
// The rate is set by the single line store: one read and one write per cycle.
// Reset is synchronous and active high; the line store is not cleared, since
// every entry is written in the first row before any later row reads it.
// A stalled result holds the output register and then the compute stage, and
// req_tready drops only when both are full.
`include "grid_min_cost_path_unit_assert.svh"

module grid_min_cost_path_unit (
   input  logic                              clock,
   input  logic                              reset,
   // Cell input.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gmcp_pkg::COST_W-1:0]       req_tdata,   // [15:0] cell_cost
   // Accumulated cost output.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gmcp_pkg::PATH_W-1:0]       rsp_tdata,   // [31:0] path_cost
   output logic                              rsp_tlast,   // is_final
   // Configuration writes.
   input  logic                              csr_we,
   input  logic [gmcp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gmcp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gmcp_pkg::*;

   // Grid size, held as the index of the last row and the last column.
   row_pos_type last_row_ff, last_row_in;
   col_pos_type last_col_ff, last_col_in;

   // Raster position of the next cell to be accepted.
   row_pos_type row_pos_ff, row_pos_in;
   col_pos_type col_pos_ff, col_pos_in;

   // Line store: accumulated costs of the previous row, one entry per column.
   path_type row_store [MAX_COLS];
   path_type above_rd_ff;

   // Compute stage.
   logic                     s1_valid_ff, s1_valid_in;
   logic signed [COST_W-1:0] s1_cost_ff;
   logic                     s1_first_row_ff;
   logic                     s1_first_col_ff;
   logic                     s1_final_ff;
   col_pos_type              s1_addr_ff;
   logic                     fwd_ff;
   path_type                 fwd_data_ff;

   // Neighbors carried from the previous cell.
   path_type left_ff;
   path_type diag_ff;

   // Output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   path_type                 rsp_data_ff;
   logic                     rsp_last_ff;

   logic        req_accept;
   logic        s1_adv;
   logic        s1_fire;
   logic        at_last_col;
   logic        at_last_row;
   path_type    above;
   path_type    base;
   path_type    value;
   logic [NUM_ROWS_W-1:0] rows_wr;
   logic [NUM_COLS_W-1:0] cols_wr;

   // The compute stage moves on when the output register is free or drains.
   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && s1_adv;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_accept = req_tvalid && req_tready;

   assign at_last_col = (col_pos_ff == last_col_ff);
   assign at_last_row = (row_pos_ff == last_row_ff);

   // Configuration decode with clamping of out-of-range sizes.
   always_comb begin
      rows_wr     = csr_wdata[NUM_ROWS_W-1:0];
      cols_wr     = csr_wdata[NUM_COLS_W-1:0];
      last_row_in = last_row_ff;
      last_col_in = last_col_ff;
      if (csr_we && (csr_index == REG_NUM_ROWS)) begin
         if (rows_wr == '0) begin
            last_row_in = '0;
         end else if (rows_wr > NUM_ROWS_W'(ROWS_LIMIT)) begin
            last_row_in = ROW_W'(ROWS_LIMIT - 1);
         end else begin
            last_row_in = ROW_W'(rows_wr - 1'b1);
         end
      end
      if (csr_we && (csr_index == REG_NUM_COLS)) begin
         if (cols_wr == '0) begin
            last_col_in = '0;
         end else if (cols_wr > NUM_COLS_W'(COLS_LIMIT)) begin
            last_col_in = COL_W'(COLS_LIMIT - 1);
         end else begin
            last_col_in = COL_W'(cols_wr - 1'b1);
         end
      end
   end

   // Raster counters; a write to either size register restarts the grid.
   always_comb begin
      row_pos_in = row_pos_ff;
      col_pos_in = col_pos_ff;
      if (csr_we && ((csr_index == REG_NUM_ROWS) || (csr_index == REG_NUM_COLS))) begin
         row_pos_in = '0;
         col_pos_in = '0;
      end else if (req_accept) begin
         if (at_last_col) begin
            col_pos_in = '0;
            row_pos_in = at_last_row ? '0 : row_pos_ff + 1'b1;
         end else begin
            col_pos_in = col_pos_ff + 1'b1;
         end
      end
   end

   // The entry above comes from the store, or straight from the cell being
   // written when the same column was read in that cycle (one-column grids).
   assign above = fwd_ff ? fwd_data_ff : above_rd_ff;

   always_comb begin
      if (s1_first_row_ff && s1_first_col_ff) begin
         base = '0;
      end else if (s1_first_row_ff) begin
         base = left_ff;
      end else if (s1_first_col_ff) begin
         base = above;
      end else begin
         base = path_min(path_min(above, left_ff), diag_ff);
      end
      value = base + PATH_W'(s1_cost_ff);
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_row_ff  <= ROW_W'(3);
         last_col_ff  <= COL_W'(3);
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
         left_ff      <= '0;
         diag_ff      <= '0;
      end else begin
         last_row_ff  <= last_row_in;
         last_col_ff  <= last_col_in;
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // The forwarding flag belongs to the cell in the compute stage and
         // is dropped when that cell leaves with nothing behind it.
         if (req_accept) begin
            fwd_ff <= s1_fire && (s1_addr_ff == col_pos_ff);
         end else if (s1_fire) begin
            fwd_ff <= 1'b0;
         end
         if (s1_fire) begin
            left_ff <= value;
            diag_ff <= above;
         end
      end
   end

   // Line store: read on acceptance, written back when the cell completes.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         above_rd_ff <= row_store[col_pos_ff];
      end
      if (s1_fire) begin
         row_store[s1_addr_ff] <= value;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cost_ff      <= req_tdata;
         s1_first_row_ff <= (row_pos_ff == '0);
         s1_first_col_ff <= (col_pos_ff == '0);
         s1_final_ff     <= at_last_row && at_last_col;
         s1_addr_ff      <= col_pos_ff;
         fwd_data_ff     <= value;
      end
      if (s1_fire) begin
         rsp_data_ff <= value;
         rsp_last_ff <= s1_final_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `GMCP_ASSERT_IMPL(a_pos_in_grid, clock, reset,
      1'b1, (col_pos_ff <= last_col_ff) && (row_pos_ff <= last_row_ff),
      "raster position beyond grid size")
   `GMCP_ASSERT_IMPL(a_fwd_needs_item, clock, reset,
      fwd_ff, s1_valid_ff, "forwarding flagged with no cell in the compute stage")
   `GMCP_ASSERT_NEXT(a_fwd_same_col, clock, reset,
      req_accept && s1_fire && (s1_addr_ff == col_pos_ff), fwd_ff,
      "same-column read and write not forwarded")
   `GMCP_ASSERT_NEXT(a_wrap_after_final, clock, reset,
      req_accept && at_last_row && at_last_col,
      (row_pos_ff == '0) && (col_pos_ff == '0),
      "raster counters did not wrap after the bottom-right cell")
   `GMCP_ASSERT_IMPL(a_stall_blocks_input, clock, reset,
      s1_valid_ff && !s1_adv, !req_tready,
      "cell accepted while the compute stage is stalled")

endmodule
